FILE: hdl/skrc_pkg.sv
// Shared types, constants and tables for the soft-knee RMS compressor.
`timescale 1ns / 1ps
package skrc_pkg;

	localparam int MAX_CH     = 8;
	localparam int DIV_STEPS  = 50;
	localparam int LOG_STEPS  = 16;
	localparam int GAIN_STEPS = 16;

	localparam logic signed [15:0] LEVEL_FLOOR = -16'sd30720;
	localparam logic [14:0] ENV_LIMIT  = 15'd25600;
	localparam logic [17:0] DB_PER_OCT = 18'd197283;  // 10*log10(2), Q2.16
	localparam logic [13:0] OCT_PER_DB = 14'd10885;   // log2(10)/20, Q0.16
	localparam logic [21:0] LG_TOP     = 22'(46 * 65536);

	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_KNEE      = 3'd1;
	localparam logic [2:0] REG_RATIO     = 3'd2;
	localparam logic [2:0] REG_ATTACK    = 3'd3;
	localparam logic [2:0] REG_RELEASE   = 3'd4;
	localparam logic [2:0] REG_CHANNELS  = 3'd5;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic [13:0]        knee;
		logic [12:0]        ratio;
		logic [23:0]        attack;
		logic [23:0]        release_c;
		logic [3:0]         chans;
	} cfg_t;

	typedef enum logic [1:0] {
		MODE_HARD,
		MODE_ZERO,
		MODE_KNEE
	} mode_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_SQ, OP_DLD_MS, OP_DSTEP, OP_MLD, OP_NORM,
		OP_LOGMUL, OP_LOGACC, OP_LVLMUL, OP_LVL, OP_DLD_R, OP_SLOPE,
		OP_HMUL, OP_KMUL1, OP_KMUL2, OP_DLD_K, OP_TGT, OP_EMUL, OP_ENV,
		OP_PMUL, OP_PLD, OP_GMUL, OP_GRND, OP_GSH, OP_OMUL, OP_ORND, OP_PUSH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_DLD_MS, ST_DIV_MS, ST_MLD, ST_NORM, ST_LOGMUL,
		ST_LOGACC, ST_LVLMUL, ST_LVL, ST_DLD_R, ST_DIV_R, ST_SLOPE, ST_HMUL,
		ST_KMUL1, ST_KMUL2, ST_DLD_K, ST_DIV_K, ST_TGT, ST_EMUL, ST_ENV,
		ST_PMUL, ST_PLD, ST_GMUL, ST_GRND, ST_GSH, ST_OMUL, ST_ORND, ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] idx;
		logic       first;
	} dp_cmd_t;

	typedef struct packed {
		logic       norm_done;
		mode_t      mode;
		logic [3:0] n_ch;
	} dp_sts_t;

	typedef logic [15:0][29:0] tk_tab_t;

	// integer square root, bit by bit; only evaluated at elaboration
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] vv;
		logic [63:0] r;
		logic [63:0] b;
		vv = v;
		r  = '0;
		b  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (vv >= r + b) begin
				vv = vv - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-k) in Q0.30 for k = 1..16
	function automatic tk_tab_t tk_build();
		tk_tab_t     tab;
		logic [63:0] t;
		t = isqrt64(64'd1 << 59);
		for (int k = 0; k < 16; k++) begin
			tab[k] = t[29:0];
			t = isqrt64(t << 30);
		end
		return tab;
	endfunction

	localparam tk_tab_t TK_TAB = tk_build();

endpackage

FILE: hdl/skrc_cfg.sv
// Configuration register file of the compressor.
`timescale 1ns / 1ps
module skrc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  logic [2:0]          wr_index,
	input  logic [23:0]         wr_data,
	output skrc_pkg::cfg_t      cfg
);

	skrc_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= -16'sd6144;
			cfg_q.knee      <= 14'd7680;
			cfg_q.ratio     <= 13'd3072;
			cfg_q.attack    <= 24'd16661116;
			cfg_q.release_c <= 24'd16775818;
			cfg_q.chans     <= 4'd2;
		end else if (wr_valid) begin
			case (wr_index)
				skrc_pkg::REG_THRESHOLD: cfg_q.threshold <= $signed(wr_data[15:0]);
				skrc_pkg::REG_KNEE:      cfg_q.knee      <= wr_data[13:0];
				skrc_pkg::REG_RATIO:     cfg_q.ratio     <= wr_data[12:0];
				skrc_pkg::REG_ATTACK:    cfg_q.attack    <= wr_data;
				skrc_pkg::REG_RELEASE:   cfg_q.release_c <= wr_data;
				skrc_pkg::REG_CHANNELS:  cfg_q.chans     <= wr_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/skrc_dp.sv
// Datapath: shared multiplier, serial divider, log/gain iterations and result buffer.
`timescale 1ns / 1ps
module skrc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skrc_pkg::dp_cmd_t     cmd,
	input  skrc_pkg::cfg_t        cfg,
	input  logic [7:0][23:0]      samples,
	output skrc_pkg::dp_sts_t     sts,
	output logic [207:0]          res_data
);

	logic [23:0]        a_q [8];
	logic               neg_q [8];
	logic [23:0]        outw_q [8];
	logic [7:0][23:0]   res_ch_q;
	logic [14:0]        res_red_q;
	logic [3:0]         n_q;
	logic [49:0]        acc_q;
	logic [63:0]        prod_q;
	logic [49:0]        dq_q;
	logic [33:0]        rem_q;
	logic [32:0]        den_q;
	logic [46:0]        m_q;
	logic [5:0]         e_q;
	logic               zero_q;
	logic [31:0]        y_q;
	logic [15:0]        frac_q;
	logic signed [15:0] x_q;
	logic [16:0]        s_q;
	logic [15:0]        ov_q;
	logic               opos_q;
	logic [14:0]        d_q;
	skrc_pkg::mode_t    mode_q;
	logic [14:0]        tgt_q;
	logic [14:0]        env_q;
	logic [4:0]         whole_q;
	logic [15:0]        bits_q;
	logic [30:0]        g_q;

	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [33:0]        dtry;
	logic               dge;
	logic [2:0]         ch;
	logic               norm_done;
	logic [3:0]         n_eff;
	logic [12:0]        r_eff;
	logic [21:0]        lg;
	logic [21:0]        xx;
	logic [39:0]        lvl_sum;
	logic [15:0]        dbm;
	logic signed [16:0] over;
	logic signed [18:0] ov2;
	logic signed [18:0] dk;
	logic signed [18:0] knee_s;
	logic               hard;
	logic [49:0]        gr;
	logic               up;
	logic [14:0]        diff;
	logic [23:0]        coef;
	logic [24:0]        cm;
	logic [39:0]        es;
	logic [15:0]        step;
	logic [15:0]        nenv;
	logic [31:0]        lv;
	logic [60:0]        grnd;
	logic [54:0]        orr;
	logic [23:0]        omag;

	assign ch        = cmd.idx[2:0];
	assign norm_done = m_q[46] | zero_q;
	assign n_eff     = (cfg.chans == 4'd0) ? 4'd1 :
		(cfg.chans > 4'(skrc_pkg::MAX_CH)) ? 4'(skrc_pkg::MAX_CH) : cfg.chans;
	assign r_eff     = (cfg.ratio < 13'd256) ? 13'd256 : cfg.ratio;

	assign sts.norm_done = norm_done;
	assign sts.mode      = mode_q;
	assign sts.n_ch      = n_q;

	assign res_data = {1'b0, res_red_q, res_ch_q};

	// restoring divider step
	assign dtry = {rem_q[32:0], dq_q[49]};
	assign dge  = dtry >= {1'b0, den_q};

	always_comb begin
		lg      = {e_q, frac_q};
		xx      = (lg >= skrc_pkg::LG_TOP) ? 22'd0 : skrc_pkg::LG_TOP - lg;
		lvl_sum = prod_q[39:0] + 40'(1 << 23);
		dbm     = lvl_sum[39:24];
		over    = 17'(x_q) - 17'(cfg.threshold);
		ov2     = {over[16], over, 1'b0};
		knee_s  = $signed({5'b0, cfg.knee});
		dk      = ov2 + knee_s;
		hard    = (cfg.knee == 14'd0) || (ov2 >= knee_s);
		case (mode_q)
			skrc_pkg::MODE_HARD: gr = opos_q ? 50'(prod_q[32:16]) : 50'd0;
			skrc_pkg::MODE_KNEE: gr = dq_q;
			default:             gr = 50'd0;
		endcase
		up   = tgt_q > env_q;
		diff = up ? tgt_q - env_q : env_q - tgt_q;
		coef = up ? cfg.attack : cfg.release_c;
		cm   = 25'(1 << 24) - 25'(coef);
		es   = prod_q[39:0] + 40'((1 << 24) - 1);
		step = es[39:24];
		nenv = up ? 16'(env_q) + step : 16'(env_q) - step;
		lv   = prod_q[61:30];
		grnd = prod_q[60:0] + 61'(1 << 29);
		orr  = prod_q[54:0] + 55'(1 << 29);
		omag = orr[53:30];
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.op)
			skrc_pkg::OP_SQ:     begin mul_a = 32'(a_q[ch]);  mul_b = 32'(a_q[ch]); end
			skrc_pkg::OP_LOGMUL: begin mul_a = y_q;           mul_b = y_q; end
			skrc_pkg::OP_LVLMUL: begin mul_a = 32'(xx);       mul_b = 32'(skrc_pkg::DB_PER_OCT); end
			skrc_pkg::OP_HMUL:   begin mul_a = 32'(ov_q);     mul_b = 32'(s_q); end
			skrc_pkg::OP_KMUL1:  begin mul_a = 32'(d_q);      mul_b = 32'(d_q); end
			skrc_pkg::OP_KMUL2:  begin mul_a = prod_q[31:0];  mul_b = 32'(s_q); end
			skrc_pkg::OP_EMUL:   begin mul_a = 32'(diff);     mul_b = 32'(cm); end
			skrc_pkg::OP_PMUL:   begin mul_a = 32'(env_q);    mul_b = 32'(skrc_pkg::OCT_PER_DB); end
			skrc_pkg::OP_GMUL:   begin
				mul_a = 32'(g_q);
				mul_b = 32'(skrc_pkg::TK_TAB[cmd.idx]);
			end
			skrc_pkg::OP_OMUL:   begin mul_a = 32'(a_q[ch]);  mul_b = 32'(g_q); end
			default:             begin mul_a = '0;            mul_b = '0; end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// envelope is the only state that survives between frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.op == skrc_pkg::OP_ENV) begin
			env_q <= (nenv > 16'(skrc_pkg::ENV_LIMIT)) ? skrc_pkg::ENV_LIMIT : nenv[14:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			skrc_pkg::OP_LOAD: begin
				for (int i = 0; i < 8; i++) begin
					a_q[i]    <= samples[i][23] ? 24'd0 - samples[i] : samples[i];
					neg_q[i]  <= samples[i][23];
					outw_q[i] <= '0;
				end
				n_q   <= n_eff;
				acc_q <= '0;
			end
			skrc_pkg::OP_SQ: begin
				prod_q <= mul_p;
				if (!cmd.first) begin
					acc_q <= acc_q + prod_q[49:0];
				end
			end
			skrc_pkg::OP_DLD_MS: begin
				dq_q  <= acc_q;
				rem_q <= '0;
				den_q <= 33'(n_q);
			end
			skrc_pkg::OP_DSTEP: begin
				rem_q <= dge ? dtry - {1'b0, den_q} : dtry;
				dq_q  <= {dq_q[48:0], dge};
			end
			skrc_pkg::OP_MLD: begin
				m_q    <= dq_q[46:0];
				e_q    <= 6'd46;
				zero_q <= (dq_q == 50'd0);
			end
			skrc_pkg::OP_NORM: begin
				if (!norm_done) begin
					m_q <= {m_q[45:0], 1'b0};
					e_q <= e_q - 6'd1;
				end else begin
					y_q    <= {1'b0, m_q[46:16]};
					frac_q <= '0;
				end
			end
			skrc_pkg::OP_LOGACC: begin
				if (lv[31]) begin
					y_q    <= {1'b0, lv[31:1]};
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					y_q    <= lv;
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			skrc_pkg::OP_LVL: begin
				x_q <= (zero_q || dbm > 16'd30720) ? skrc_pkg::LEVEL_FLOOR : $signed(16'd0 - dbm);
			end
			skrc_pkg::OP_DLD_R: begin
				dq_q  <= 50'(1 << 24);
				rem_q <= '0;
				den_q <= 33'(r_eff);
			end
			skrc_pkg::OP_SLOPE: begin
				s_q    <= 17'(65536) - dq_q[16:0];
				ov_q   <= over[15:0];
				opos_q <= over > 17'sd0;
				d_q    <= dk[14:0];
				if (hard) begin
					mode_q <= skrc_pkg::MODE_HARD;
				end else if (dk <= 19'sd0) begin
					mode_q <= skrc_pkg::MODE_ZERO;
				end else begin
					mode_q <= skrc_pkg::MODE_KNEE;
				end
			end
			skrc_pkg::OP_DLD_K: begin
				dq_q  <= prod_q[49:0];
				rem_q <= '0;
				den_q <= {cfg.knee, 19'd0};
			end
			skrc_pkg::OP_TGT: begin
				tgt_q <= (gr > 50'(skrc_pkg::ENV_LIMIT)) ? skrc_pkg::ENV_LIMIT : gr[14:0];
			end
			skrc_pkg::OP_PLD: begin
				whole_q <= prod_q[28:24];
				bits_q  <= prod_q[23:8];
				g_q     <= 31'(1 << 30);
			end
			skrc_pkg::OP_GRND: begin
				if (bits_q[~cmd.idx]) begin
					g_q <= grnd[60:30];
				end
			end
			skrc_pkg::OP_GSH: begin
				g_q <= g_q >> whole_q;
			end
			skrc_pkg::OP_ORND: begin
				outw_q[ch] <= neg_q[ch] ? 24'd0 - omag : omag;
			end
			skrc_pkg::OP_PUSH: begin
				for (int i = 0; i < 8; i++) begin
					res_ch_q[i] <= outw_q[i];
				end
				res_red_q <= env_q;
			end
			skrc_pkg::OP_LOGMUL, skrc_pkg::OP_LVLMUL, skrc_pkg::OP_HMUL,
			skrc_pkg::OP_KMUL1, skrc_pkg::OP_KMUL2, skrc_pkg::OP_EMUL,
			skrc_pkg::OP_PMUL, skrc_pkg::OP_GMUL, skrc_pkg::OP_OMUL: begin
				prod_q <= mul_p;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/skrc_ctrl.sv
// Sequencer for one frame: issues datapath commands and runs the handshakes.
`timescale 1ns / 1ps
module skrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_present,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  skrc_pkg::dp_sts_t     sts,
	output skrc_pkg::dp_cmd_t     cmd
);

	skrc_pkg::ctrl_state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       ovalid_q;
	logic       push;

	assign in_ready  = (state_q == skrc_pkg::ST_IDLE);
	assign out_valid = ovalid_q;
	assign push      = (state_q == skrc_pkg::ST_DONE) && (!ovalid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= skrc_pkg::ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd.op    = skrc_pkg::OP_NOP;
		cmd.idx   = cnt_q[3:0];
		cmd.first = (cnt_q == 6'd0);
		case (state_q)
			skrc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = skrc_pkg::OP_LOAD;
					cnt_d   = '0;
					state_d = in_present ? skrc_pkg::ST_SQ : skrc_pkg::ST_DONE;
				end
			end
			skrc_pkg::ST_SQ: begin
				cmd.op = skrc_pkg::OP_SQ;
				if (cnt_q == 6'(sts.n_ch)) begin
					cnt_d   = '0;
					state_d = skrc_pkg::ST_DLD_MS;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			skrc_pkg::ST_DLD_MS: begin
				cmd.op  = skrc_pkg::OP_DLD_MS;
				state_d = skrc_pkg::ST_DIV_MS;
			end
			skrc_pkg::ST_DIV_MS, skrc_pkg::ST_DIV_R, skrc_pkg::ST_DIV_K: begin
				cmd.op = skrc_pkg::OP_DSTEP;
				if (cnt_q == 6'(skrc_pkg::DIV_STEPS - 1)) begin
					cnt_d = '0;
					case (state_q)
						skrc_pkg::ST_DIV_MS: state_d = skrc_pkg::ST_MLD;
						skrc_pkg::ST_DIV_R:  state_d = skrc_pkg::ST_SLOPE;
						default:             state_d = skrc_pkg::ST_TGT;
					endcase
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			skrc_pkg::ST_MLD: begin
				cmd.op  = skrc_pkg::OP_MLD;
				state_d = skrc_pkg::ST_NORM;
			end
			skrc_pkg::ST_NORM: begin
				cmd.op = skrc_pkg::OP_NORM;
				if (sts.norm_done) begin
					cnt_d   = '0;
					state_d = skrc_pkg::ST_LOGMUL;
				end
			end
			skrc_pkg::ST_LOGMUL: begin
				cmd.op  = skrc_pkg::OP_LOGMUL;
				state_d = skrc_pkg::ST_LOGACC;
			end
			skrc_pkg::ST_LOGACC: begin
				cmd.op = skrc_pkg::OP_LOGACC;
				if (cnt_q == 6'(skrc_pkg::LOG_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = skrc_pkg::ST_LVLMUL;
				end else begin
					cnt_d   = cnt_q + 6'd1;
					state_d = skrc_pkg::ST_LOGMUL;
				end
			end
			skrc_pkg::ST_LVLMUL: begin
				cmd.op  = skrc_pkg::OP_LVLMUL;
				state_d = skrc_pkg::ST_LVL;
			end
			skrc_pkg::ST_LVL: begin
				cmd.op  = skrc_pkg::OP_LVL;
				state_d = skrc_pkg::ST_DLD_R;
			end
			skrc_pkg::ST_DLD_R: begin
				cmd.op  = skrc_pkg::OP_DLD_R;
				cnt_d   = '0;
				state_d = skrc_pkg::ST_DIV_R;
			end
			skrc_pkg::ST_SLOPE: begin
				cmd.op  = skrc_pkg::OP_SLOPE;
				state_d = skrc_pkg::ST_HMUL;
			end
			skrc_pkg::ST_HMUL: begin
				// mode was settled by the preceding slope step
				case (sts.mode)
					skrc_pkg::MODE_HARD: begin
						cmd.op  = skrc_pkg::OP_HMUL;
						state_d = skrc_pkg::ST_TGT;
					end
					skrc_pkg::MODE_KNEE: begin
						cmd.op  = skrc_pkg::OP_KMUL1;
						state_d = skrc_pkg::ST_KMUL2;
					end
					default: begin
						state_d = skrc_pkg::ST_TGT;
					end
				endcase
			end
			skrc_pkg::ST_KMUL1: begin
				cmd.op  = skrc_pkg::OP_KMUL1;
				state_d = skrc_pkg::ST_KMUL2;
			end
			skrc_pkg::ST_KMUL2: begin
				cmd.op  = skrc_pkg::OP_KMUL2;
				state_d = skrc_pkg::ST_DLD_K;
			end
			skrc_pkg::ST_DLD_K: begin
				cmd.op  = skrc_pkg::OP_DLD_K;
				cnt_d   = '0;
				state_d = skrc_pkg::ST_DIV_K;
			end
			skrc_pkg::ST_TGT: begin
				cmd.op  = skrc_pkg::OP_TGT;
				state_d = skrc_pkg::ST_EMUL;
			end
			skrc_pkg::ST_EMUL: begin
				cmd.op  = skrc_pkg::OP_EMUL;
				state_d = skrc_pkg::ST_ENV;
			end
			skrc_pkg::ST_ENV: begin
				cmd.op  = skrc_pkg::OP_ENV;
				state_d = skrc_pkg::ST_PMUL;
			end
			skrc_pkg::ST_PMUL: begin
				cmd.op  = skrc_pkg::OP_PMUL;
				state_d = skrc_pkg::ST_PLD;
			end
			skrc_pkg::ST_PLD: begin
				cmd.op  = skrc_pkg::OP_PLD;
				cnt_d   = '0;
				state_d = skrc_pkg::ST_GMUL;
			end
			skrc_pkg::ST_GMUL: begin
				cmd.op  = skrc_pkg::OP_GMUL;
				state_d = skrc_pkg::ST_GRND;
			end
			skrc_pkg::ST_GRND: begin
				cmd.op = skrc_pkg::OP_GRND;
				if (cnt_q == 6'(skrc_pkg::GAIN_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = skrc_pkg::ST_GSH;
				end else begin
					cnt_d   = cnt_q + 6'd1;
					state_d = skrc_pkg::ST_GMUL;
				end
			end
			skrc_pkg::ST_GSH: begin
				cmd.op  = skrc_pkg::OP_GSH;
				cnt_d   = '0;
				state_d = skrc_pkg::ST_OMUL;
			end
			skrc_pkg::ST_OMUL: begin
				cmd.op  = skrc_pkg::OP_OMUL;
				state_d = skrc_pkg::ST_ORND;
			end
			skrc_pkg::ST_ORND: begin
				cmd.op = skrc_pkg::OP_ORND;
				if (cnt_q == 6'(sts.n_ch) - 6'd1) begin
					cnt_d   = '0;
					state_d = skrc_pkg::ST_DONE;
				end else begin
					cnt_d   = cnt_q + 6'd1;
					state_d = skrc_pkg::ST_OMUL;
				end
			end
			skrc_pkg::ST_DONE: begin
				if (push) begin
					cmd.op  = skrc_pkg::OP_PUSH;
					state_d = skrc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skrc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/soft_knee_rms_compressor.sv
// Top level of the soft-knee RMS compressor: config, sequencer and datapath.
`timescale 1ns / 1ps
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: sample_ch0..7, tuser: frame_present,
//                                        tlast: last_of_block
//  m_axis    out  tvalid/tready          tdata: out_ch0..7, reduction_level
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One frame at a time. A present frame runs from accept to result through
//  the sum of squares at one channel per cycle, the one-bit-per-cycle divider
//  (two 50-step divisions, a third in the soft knee), the normalising shift,
//  the 16-step log and gain loops and a multiply and a rounding step per
//  channel for the outputs. An absent frame skips all of these and goes
//  straight to the output register. The result sits in an output register,
//  so the next word is taken the cycle after it is loaded; a stalled result
//  only holds the block once the next frame is finished. Reset clears the
//  envelope and loads the register defaults; there is no start-up sweep.
//
module soft_knee_rms_compressor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,   // sample_ch0 [23:0] .. sample_ch7 [191:168]
	input  logic         s_axis_tuser,   // frame_present
	input  logic         s_axis_tlast,   // last_of_block, not used in the processing
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,   // out_ch0 [23:0] .. out_ch7 [191:168],
	                                     // reduction_level [206:192], pad [207]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	skrc_pkg::cfg_t    cfg;
	skrc_pkg::dp_cmd_t cmd;
	skrc_pkg::dp_sts_t sts;
	logic [7:0][23:0]  samples;
	logic              block_mark;

	assign samples    = s_axis_tdata;
	// the block marker has no bearing on the processing
	assign block_mark = s_axis_tlast;

	skrc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	skrc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_present (s_axis_tuser | (block_mark & 1'b0)),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	skrc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.samples  (samples),
		.sts      (sts),
		.res_data (m_axis_tdata)
	);

	// one frame in flight: no second word straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a frame is still being worked on");

	// reported reduction never leaves the envelope range
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[206:192] <= 15'd25600))
		else $error("reduction level above limit");

endmodule
